### src/hsc_pkg.sv
// hsc_pkg: shared types, constants and position tables for the hamming sec codec
// no dependencies; used by every module under src
package hsc_pkg;

  localparam int WORD_W        = 62;  // widest codeword in bits
  localparam int BYTE_BITS     = 8;
  localparam int DATA_MAX      = 56;  // data bits at seven bytes
  localparam int SYN_W         = 6;   // syndrome / position width
  localparam int BYTES_W       = 3;   // width of the data byte count
  localparam int MAX_BYTES_DEF = 7;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  // codeword length n = 8*bytes + check bits, indexed by byte count
  // (entry 0 is never selected, the byte count is clamped to at least one)
  localparam logic [SYN_W-1:0] CODE_LEN [0:7] = '{
    6'd12, 6'd12, 6'd21, 6'd29, 6'd38, 6'd46, 6'd54, 6'd62
  };

  // one row in flight, held as a 1-based position vector
  typedef struct packed {
    op_t                op;
    logic [BYTES_W-1:0] nbytes;
    logic [WORD_W:1]    pos;
  } row_t;

  // position of the k-th data bit (k from 0): k-th non-power-of-two position
  function automatic int data_pos(int k);
    int p;
    int seen;
    p    = 0;
    seen = -1;
    while (seen < k) begin
      p++;
      if ((p & (p - 1)) != 0) seen++;
    end
    return p;
  endfunction

  // positions covered by syndrome bit i
  function automatic logic [WORD_W:1] syn_mask(int i);
    logic [WORD_W:1] m;
    for (int p = 1; p <= WORD_W; p++) begin
      m[p] = ((p >> i) & 1) == 1;
    end
    return m;
  endfunction

endpackage

### src/hsc_cfg.sv
// hsc_cfg: data byte count register with clamping to the supported range
// depends on hsc_pkg
module hsc_cfg #(
  parameter int MAX_BYTES = hsc_pkg::MAX_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hsc_pkg::BYTES_W-1:0] cfg_data,
  output logic [hsc_pkg::BYTES_W-1:0] nbytes
);

  logic [hsc_pkg::BYTES_W-1:0] nbytes_next;

  assign cfg_ready = 1'b1;

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (cfg_data == '0) begin
      nbytes_next = hsc_pkg::BYTES_W'(1);
    end else if (cfg_data > hsc_pkg::BYTES_W'(MAX_BYTES)) begin
      nbytes_next = hsc_pkg::BYTES_W'(MAX_BYTES);
    end else begin
      nbytes_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nbytes <= hsc_pkg::BYTES_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      nbytes <= nbytes_next;
    end
  end

endmodule

### src/hsc_place.sv
// hsc_place: first stage, maps the input word onto the 1-based position vector
// depends on hsc_pkg
module hsc_place (
  input  logic                               clk,
  input  logic                               load,
  input  logic                               operation,
  input  logic [hsc_pkg::WORD_W-1:0]         word,
  input  logic [hsc_pkg::BYTES_W-1:0]        nbytes,
  output hsc_pkg::row_t                      row
);

  localparam int W = hsc_pkg::WORD_W;
  localparam int D = hsc_pkg::DATA_MAX;

  logic [hsc_pkg::SYN_W-1:0] code_len;
  logic [hsc_pkg::SYN_W-1:0] data_len;
  logic [W-1:0]              cw_left;   // codeword, position 1 at the msb
  logic [D-1:0]              d_left;    // data, first bit at the msb
  logic [W:1]                enc_pos;
  logic [W:1]                dec_pos;
  hsc_pkg::row_t             row_next;

  assign code_len = hsc_pkg::CODE_LEN[nbytes];
  assign data_len = {nbytes, 3'b000};
  assign cw_left  = word << (hsc_pkg::SYN_W'(W) - code_len);
  assign d_left   = word[D-1:0] << (hsc_pkg::SYN_W'(D) - data_len);

  // unused positions and all check positions stay zero on encode
  always_comb begin
    enc_pos = '0;
    for (int k = 0; k < D; k++) begin
      enc_pos[hsc_pkg::data_pos(k)] = d_left[D-1-k];
    end
  end

  genvar p;
  generate
    for (p = 1; p <= W; p++) begin : g_dec
      assign dec_pos[p] = cw_left[W-p];
    end
  endgenerate

  always_comb begin
    row_next.op     = hsc_pkg::op_t'(operation);
    row_next.nbytes = nbytes;
    row_next.pos    = (row_next.op == hsc_pkg::OP_DECODE) ? dec_pos : enc_pos;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row <= row_next;
    end
  end

endmodule

### src/hsc_syndrome.sv
// hsc_syndrome: second stage, xor trees over the position vector
// depends on hsc_pkg
module hsc_syndrome (
  input  logic                       clk,
  input  logic                       load,
  input  hsc_pkg::row_t              row_in,
  output hsc_pkg::row_t              row,
  output logic [hsc_pkg::SYN_W-1:0]  syn
);

  logic [hsc_pkg::SYN_W-1:0] syn_next;

  genvar i;
  generate
    for (i = 0; i < hsc_pkg::SYN_W; i++) begin : g_syn
      assign syn_next[i] = ^(row_in.pos & hsc_pkg::syn_mask(i));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (load) begin
      row <= row_in;
      syn <= syn_next;
    end
  end

endmodule

### src/hsc_correct.sv
// hsc_correct: last stage, check bit insertion or single bit fix, realignment
// depends on hsc_pkg
module hsc_correct (
  input  logic                        clk,
  input  logic                        load,
  input  hsc_pkg::row_t               row,
  input  logic [hsc_pkg::SYN_W-1:0]   syn,
  output logic [hsc_pkg::WORD_W-1:0]  result_word,
  output logic [hsc_pkg::SYN_W-1:0]   error_position,
  output logic                        uncorrectable
);

  localparam int W = hsc_pkg::WORD_W;
  localparam int D = hsc_pkg::DATA_MAX;

  logic [hsc_pkg::SYN_W-1:0] code_len;
  logic [hsc_pkg::SYN_W-1:0] data_len;
  logic [W:1]                flip;
  logic [W:1]                fix_pos;
  logic [W:1]                enc_pos;
  logic [W-1:0]              enc_left;
  logic [D-1:0]              d_left;
  logic                      is_dec;
  logic                      past_end;
  logic [W-1:0]              word_next;

  assign code_len = hsc_pkg::CODE_LEN[row.nbytes];
  assign data_len = {row.nbytes, 3'b000};
  assign is_dec   = (row.op == hsc_pkg::OP_DECODE);
  assign past_end = (syn > code_len);

  // one-hot flip of the named position, only inside the codeword
  always_comb begin
    flip = '0;
    for (int p = 1; p <= W; p++) begin
      flip[p] = (syn == hsc_pkg::SYN_W'(p)) && !past_end;
    end
  end
  assign fix_pos = row.pos ^ flip;

  // check positions are zero on encode, so the syndrome bits drop in directly
  always_comb begin
    enc_pos = row.pos;
    for (int i = 0; i < hsc_pkg::SYN_W; i++) begin
      enc_pos[1 << i] = syn[i];
    end
  end

  always_comb begin
    for (int k = 0; k < D; k++) begin
      d_left[D-1-k] = fix_pos[hsc_pkg::data_pos(k)];
    end
  end

  genvar p;
  generate
    for (p = 1; p <= W; p++) begin : g_enc
      assign enc_left[W-p] = enc_pos[p];
    end
  endgenerate

  always_comb begin
    if (is_dec) begin
      word_next = W'(d_left >> (hsc_pkg::SYN_W'(D) - data_len));
    end else begin
      word_next = enc_left >> (hsc_pkg::SYN_W'(W) - code_len);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_word    <= word_next;
      error_position <= is_dec ? syn : '0;
      uncorrectable  <= is_dec && past_end;
    end
  end

endmodule

### src/hamming_sec_codec.sv
// hamming_sec_codec: single error correcting hamming encoder/decoder, 8 to 56 data bits
// throughput one word per cycle while result_stall is low
// stages: position placement, syndrome xor trees, correction and realignment
// a stall at the result side holds each full stage; empty stages keep filling
// synchronous active-high reset empties the pipeline and sets data_bytes to 1
// depends on hsc_pkg, hsc_cfg, hsc_place, hsc_syndrome, hsc_correct
module hamming_sec_codec #(
  parameter int MAX_BYTES = hsc_pkg::MAX_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input word channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        operation,
  input  logic [hsc_pkg::WORD_W-1:0]  word,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [hsc_pkg::WORD_W-1:0]  result_word,
  output logic [hsc_pkg::SYN_W-1:0]   error_position,
  output logic                        uncorrectable,
  // data_bytes register write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hsc_pkg::BYTES_W-1:0] cfg_data
);

  logic [hsc_pkg::BYTES_W-1:0] nbytes;
  hsc_pkg::row_t               row1;
  hsc_pkg::row_t               row2;
  logic [hsc_pkg::SYN_W-1:0]   syn2;

  // stage valid bits
  logic v1;
  logic v2;
  logic v3;
  // a stage can take a word when it is empty or its word moves on
  logic ready1;
  logic ready2;
  logic ready3;

  assign ready3       = !v3 || !result_stall;
  assign ready2       = !v2 || ready3;
  assign ready1       = !v1 || ready2;
  assign item_stall   = !ready1;
  assign result_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= item_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  // clamped byte count register
  hsc_cfg #(
    .MAX_BYTES (MAX_BYTES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .nbytes    (nbytes)
  );

  // stage 1: left align and scatter onto codeword positions
  hsc_place u_place (
    .clk       (clk),
    .load      (ready1 && item_valid),
    .operation (operation),
    .word      (word),
    .nbytes    (nbytes),
    .row       (row1)
  );

  // stage 2: syndrome (check bits on encode)
  hsc_syndrome u_syndrome (
    .clk    (clk),
    .load   (ready2 && v1),
    .row_in (row1),
    .row    (row2),
    .syn    (syn2)
  );

  // stage 3: insert check bits or fix one bit, then right align
  hsc_correct u_correct (
    .clk            (clk),
    .load           (ready3 && v2),
    .row            (row2),
    .syn            (syn2),
    .result_word    (result_word),
    .error_position (error_position),
    .uncorrectable  (uncorrectable)
  );

  // a flagged word always carries the offending syndrome
  a_unc_has_syn: assert property (@(posedge clk) disable iff (rst)
    result_valid && uncorrectable |-> error_position != '0)
    else $error("uncorrectable set with zero syndrome");

  // an accepted word always lands in stage 1
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> v1)
    else $error("accepted word lost at stage 1");

  // a blocked middle stage keeps its word
  a_mid_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !ready3 |=> v2)
    else $error("stage 2 word dropped under stall");

  // reset leaves the pipeline empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !v1 && !v2 && !v3)
    else $error("pipeline not empty after reset");

endmodule

### verif/hsc_tb_pkg.sv
// hsc_tb_pkg: row predictor and result checker for the hamming sec codec testbench
// depends on hsc_pkg for the operation codes and field widths
package hsc_tb_pkg;
  import hsc_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic [SYN_W-1:0]  error_position;
    logic              uncorrectable;
  } codec_result_t;

  // byte count 0 behaves as one byte
  function automatic int data_bits(logic [BYTES_W-1:0] nbytes);
    return (nbytes == '0) ? BYTE_BITS : BYTE_BITS * int'(nbytes);
  endfunction

  // fewest check bits r with 2^r - r - 1 >= data bits
  function automatic int check_bits(logic [BYTES_W-1:0] nbytes);
    int r;
    r = 1;
    while (((1 << r) - r - 1) < data_bits(nbytes)) r++;
    return r;
  endfunction

  function automatic int codeword_len(logic [BYTES_W-1:0] nbytes);
    return data_bits(nbytes) + check_bits(nbytes);
  endfunction

  // expected output for one word at the given row size
  function automatic codec_result_t hamming_code_row(op_t op, logic [WORD_W-1:0] w,
                                                     logic [BYTES_W-1:0] nbytes);
    codec_result_t res;
    logic [WORD_W-1:0] cw;
    int d;
    int n;
    int k;
    int syn;
    d   = data_bits(nbytes);
    n   = codeword_len(nbytes);
    res = '0;
    syn = 0;
    k   = 0;
    if (op == OP_ENCODE) begin
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) == 0) continue;
        if (w[d-1-k]) begin
          res.result_word[n-p] = 1'b1;
          syn ^= p;
        end
        k++;
      end
      for (int i = 0; i < check_bits(nbytes); i++) begin
        if (syn[i]) res.result_word[n-(1<<i)] = 1'b1;
      end
    end else begin
      // positions above n never enter the syndrome
      for (int p = 1; p <= n; p++) begin
        if (w[n-p]) syn ^= p;
      end
      cw = w;
      if (syn != 0 && syn <= n) cw[n-syn] = ~cw[n-syn];
      else if (syn > n) res.uncorrectable = 1'b1;
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) == 0) continue;
        res.result_word = {res.result_word[WORD_W-2:0], cw[n-p]};
      end
      res.error_position = syn[SYN_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] codeword_of(logic [WORD_W-1:0] data,
                                                    logic [BYTES_W-1:0] nbytes);
    codec_result_t enc;
    enc = hamming_code_row(OP_ENCODE, data, nbytes);
    return enc.result_word;
  endfunction

  // toggle 1-based codeword position pos of an n-bit word
  function automatic logic [WORD_W-1:0] with_error(logic [WORD_W-1:0] w, int n, int pos);
    w[n-pos] = ~w[n-pos];
    return w;
  endfunction

  class hamming_result_check;
    logic [BYTES_W-1:0] row_bytes;
    codec_result_t      expected_q[$];
    int                 mismatch_count;

    function new();
      row_bytes      = 3'd1;
      mismatch_count = 0;
    endfunction

    function void set_bytes(logic [BYTES_W-1:0] nbytes);
      row_bytes = nbytes;
    endfunction

    function void note_input(op_t op, logic [WORD_W-1:0] w);
      expected_q.insert(expected_q.size(), hamming_code_row(op, w, row_bytes));
    endfunction

    function int queued_count();
      return expected_q.size();
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%s mismatch: expected %h got %h", field, want, got);
    endfunction

    function void check_result(codec_result_t got);
      codec_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected word", '0, 64'(got.result_word));
        return;
      end
      want = expected_q.pop_front();
      if (got.result_word != want.result_word)
        report("result_word", 64'(want.result_word), 64'(got.result_word));
      if (got.error_position != want.error_position)
        report("error_position", 64'(want.error_position), 64'(got.error_position));
      if (got.uncorrectable != want.uncorrectable)
        report("uncorrectable", 64'(want.uncorrectable), 64'(got.uncorrectable));
    endfunction
  endclass

endpackage

### verif/tb.sv
// tb: self-checking testbench for hamming_sec_codec, directed corner words then random rows
// depends on hsc_pkg, hsc_tb_pkg and the codec rtl under src
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsc_pkg::*;
  import hsc_tb_pkg::*;

  localparam int PHASES         = 17;
  localparam int ROWS_PER_PHASE = 100;
  localparam int HOLD_CYCLES    = 60;    // long result-side hold, fills the pipeline
  localparam int SETTLE_CYCLES  = 6;     // longer than the pipeline latency
  localparam int WATCHDOG_LIMIT = 2000;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  logic                operation;
  logic [WORD_W-1:0]   word;
  logic                result_valid;
  logic                result_stall;
  logic [WORD_W-1:0]   result_word;
  logic [SYN_W-1:0]    error_position;
  logic                uncorrectable;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BYTES_W-1:0]  cfg_data;

  // gap switches, changed per phase by the stimulus process
  bit feed_gaps;
  bit drain_gaps;
  bit hold_out;
  int quiet_cycles;

  hamming_result_check sb = new();

  hamming_sec_codec u_top (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .word           (word),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result_word    (result_word),
    .error_position (error_position),
    .uncorrectable  (uncorrectable),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one word, optionally after a short gap, and hold it until accepted
  // valid stays high on return so back-to-back words need no re-raise
  task automatic send_row(op_t op, logic [WORD_W-1:0] w);
    if (feed_gaps && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation  <= op;
    word       <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // let the pipeline empty before touching the register
  task automatic drain_rows();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.queued_count() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_row_bytes(logic [BYTES_W-1:0] nbytes);
    drain_rows();
    cfg_valid <= 1'b1;
    cfg_data  <= nbytes;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // the largest share is real codewords with zero, one or two flips; the rest is encode
  // traffic and raw noise, all with junk above the row width
  task automatic random_row(logic [BYTES_W-1:0] nbytes);
    logic [63:0]       raw;
    logic [63:0]       junk;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] above_n;
    int                n;
    int                kind;
    raw     = {$urandom, $urandom};
    junk    = {$urandom, $urandom};
    n       = codeword_len(nbytes);
    above_n = ~((62'd1 << n) - 62'd1);
    kind    = $urandom_range(0, 99);
    if (kind < 35) begin
      send_row(OP_ENCODE, raw[WORD_W-1:0]);
    end else if (kind < 80) begin
      w = codeword_of(raw[WORD_W-1:0], nbytes) | (junk[WORD_W-1:0] & above_n);
      if (kind >= 50) w = with_error(w, n, $urandom_range(1, n));
      if (kind >= 72) w = with_error(w, n, $urandom_range(1, n));
      send_row(OP_DECODE, w);
    end else begin
      send_row(OP_DECODE, raw[WORD_W-1:0]);
    end
  endtask

  // result side: random stall bursts, plus one long hold on request
  initial begin
    result_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_out) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_out = 1'b0;
      end else if (drain_gaps && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // handshake monitor and watchdog, all sampled on pre-edge values
  always @(posedge clk) begin
    codec_result_t got;
    bit            moved;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (item_valid && !item_stall) begin
        sb.note_input(op_t'(operation), word);
        moved = 1'b1;
      end
      if (result_valid && !result_stall) begin
        got = {result_word, error_position, uncorrectable};
        sb.check_result(got);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_bytes(cfg_data);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [BYTES_W-1:0] nbytes;
    logic [WORD_W-1:0]  cw;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    operation  <= OP_ENCODE;
    word       <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    feed_gaps  = 1'b0;
    drain_gaps = 1'b0;
    hold_out   = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // one byte rows after reset, 12-bit codewords
    cw = codeword_of(62'hA5, 3'd1);
    send_row(OP_ENCODE, '0);
    send_row(OP_ENCODE, 62'hFF);
    send_row(OP_ENCODE, '1);                        // junk above the data bits
    send_row(OP_ENCODE, {54'h2A_AAAA_AAAA_AAAA, 8'h5A});
    send_row(OP_DECODE, '0);
    send_row(OP_DECODE, cw);
    send_row(OP_DECODE, with_error(cw, 12, 1));     // first position
    send_row(OP_DECODE, with_error(cw, 12, 12));    // last position
    send_row(OP_DECODE, with_error(cw, 12, 8));     // a check bit
    send_row(OP_DECODE, with_error(with_error(cw, 12, 3), 12, 6));  // double error
    send_row(OP_DECODE, 62'h801);                   // syndrome 13, past the end
    send_row(OP_DECODE, 62'hC01);                   // syndrome 15, past the end
    send_row(OP_DECODE, 62'hFFF);
    send_row(OP_DECODE, '1);                        // junk above the codeword

    // widest rows, 62-bit codewords
    program_row_bytes(3'd7);
    cw = codeword_of({6'd0, {56{1'b1}}}, 3'd7);
    send_row(OP_ENCODE, {6'd0, {56{1'b1}}});
    send_row(OP_ENCODE, '0);
    send_row(OP_ENCODE, '1);
    send_row(OP_DECODE, with_error(cw, 62, 62));
    send_row(OP_DECODE, with_error(cw, 62, 32));
    send_row(OP_DECODE, with_error(with_error('0, 62, 1), 62, 62));  // syndrome 63
    send_row(OP_DECODE, '1);                        // syndrome 63 too

    // zero byte count behaves as one byte
    program_row_bytes(3'd0);
    send_row(OP_ENCODE, 62'hFF);
    send_row(OP_DECODE, 62'hFFF);

    // random phases, every byte count in the first eight, gaps off in the last
    for (int ph = 0; ph < PHASES; ph++) begin
      nbytes = (ph < 8) ? 3'((ph * 5 + 7) % 8) : 3'($urandom_range(0, 7));
      program_row_bytes(nbytes);
      feed_gaps  = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      drain_gaps = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < ROWS_PER_PHASE; i++) begin
        if (ph == 1 && i == ROWS_PER_PHASE / 2) hold_out = 1'b1;
        random_row(nbytes);
      end
    end

    drain_rows();
    if (sb.mismatch_count == 0 && sb.queued_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
